### sv/kwc_pkg.sv
// Kaiser window coefficient unit: shared package.
// Field widths, sequencing constants, controller/datapath command and status types,
// and the reciprocal table for the series ratio. No dependencies.
package kwc_pkg;

  localparam int LEN_W   = 13;
  localparam int BETA_W  = 16;
  localparam int IDX_W   = 12;
  localparam int COEF_W  = 16;
  localparam int CNT_W   = 6;

  localparam int MAX_LENGTH   = 4096;
  localparam int SERIES_TERMS = 40;
  localparam int SQ_STEPS     = 27;
  localparam int DV_STEPS     = 32;
  localparam int RT_STEPS     = 15;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [63:0] ONE_Q16 = 64'd65536;

  localparam logic [32:0] TWO32 = 33'h1_0000_0000;

  // floor(2^32 / k^2), k = 0..63 (k = 0 unused)
  localparam logic [32:0] RECIP_TBL [64] = '{
    33'd0,          TWO32/(1*1),    TWO32/(2*2),    TWO32/(3*3),
    TWO32/(4*4),    TWO32/(5*5),    TWO32/(6*6),    TWO32/(7*7),
    TWO32/(8*8),    TWO32/(9*9),    TWO32/(10*10),  TWO32/(11*11),
    TWO32/(12*12),  TWO32/(13*13),  TWO32/(14*14),  TWO32/(15*15),
    TWO32/(16*16),  TWO32/(17*17),  TWO32/(18*18),  TWO32/(19*19),
    TWO32/(20*20),  TWO32/(21*21),  TWO32/(22*22),  TWO32/(23*23),
    TWO32/(24*24),  TWO32/(25*25),  TWO32/(26*26),  TWO32/(27*27),
    TWO32/(28*28),  TWO32/(29*29),  TWO32/(30*30),  TWO32/(31*31),
    TWO32/(32*32),  TWO32/(33*33),  TWO32/(34*34),  TWO32/(35*35),
    TWO32/(36*36),  TWO32/(37*37),  TWO32/(38*38),  TWO32/(39*39),
    TWO32/(40*40),  TWO32/(41*41),  TWO32/(42*42),  TWO32/(43*43),
    TWO32/(44*44),  TWO32/(45*45),  TWO32/(46*46),  TWO32/(47*47),
    TWO32/(48*48),  TWO32/(49*49),  TWO32/(50*50),  TWO32/(51*51),
    TWO32/(52*52),  TWO32/(53*53),  TWO32/(54*54),  TWO32/(55*55),
    TWO32/(56*56),  TWO32/(57*57),  TWO32/(58*58),  TWO32/(59*59),
    TWO32/(60*60),  TWO32/(61*61),  TWO32/(62*62),  TWO32/(63*63)
  };

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_BS_MUL,
    OP_DV_INIT,
    OP_DV_STEP,
    OP_HSQ_MUL,
    OP_SER_INIT,
    OP_T_REC,
    OP_T_CHK,
    OP_T_FIX,
    OP_T_HI,
    OP_T_LO,
    OP_T_L16,
    OP_T_SUM,
    OP_T_ACC,
    OP_RT_INIT,
    OP_RT_STEP,
    OP_RT_RND,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] k;
    logic             pass;   // 0: numerator series, 1: denominator series
  } cmd_t;

  typedef struct packed {
    logic special;    // out of range or length one
    logic term_zero;
  } stat_t;

endpackage

### sv/kaiser_window_coefficient_unit.sv
// Kaiser window coefficient unit: top level.
// Holds the APB configuration registers and joins kwc_ctrl with kwc_dpath.
// Depends on kwc_pkg, kwc_ctrl, kwc_dpath.
//
// Usage: write window_length at byte address 0 and beta_q11 (Q5.11) at address 4
// through the APB port (pready is always high), only while the unit is idle.
// Each word on the in_ channel carries a sample index; each word on the out_
// channel carries its Q1.15 coefficient and an out-of-range flag. One word is in
// flight at a time; in_ready is high only while the unit is idle.
// An index out of range or a length of one goes straight to the output. Otherwise the
// word runs 27 square-root steps, 32 divide steps, two series of up to 40 terms
// each through the shared multiplier, and a ratio of 15 steps.
// Reset: length 64, beta 8.0, no word held. A stalled receiver holds the
// finished word in the output register; the next index is still accepted and
// computed, and waits for the output register to free.
module kaiser_window_coefficient_unit import kwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_sample_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COEF_W-1:0] out_coefficient,
  output logic              out_index_out_of_range,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LEN_W-1:0]  len_r;
  logic [BETA_W-1:0] beta_r;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(beta_r) : 32'(len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(64);
      beta_r <= BETA_W'(16384);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) beta_r <= pwdata[BETA_W-1:0];
      else          len_r  <= pwdata[LEN_W-1:0];
    end
  end

  kwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kwc_dpath u_dpath (
    .clk                    (clk),
    .cmd                    (cmd),
    .in_sample_index        (in_sample_index),
    .window_length          (len_r),
    .beta_q11               (beta_r),
    .stat                   (stat),
    .out_coefficient        (out_coefficient),
    .out_index_out_of_range (out_index_out_of_range)
  );

endmodule

### sv/kwc_ctrl.sv
// Kaiser window coefficient unit: sequencing controller.
// Runs sqrt, divide, two Bessel series and the final ratio; owns both handshakes.
// Depends on kwc_pkg.
module kwc_ctrl import kwc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SQ_INIT, S_SQ_STEP, S_BS, S_DV_INIT, S_DV_STEP,
    S_HSQ, S_SER_INIT, S_T_REC, S_T_CHK, S_T_FIX, S_T_HI, S_T_LO, S_T_L16,
    S_T_SUM, S_T_ACC, S_RT_INIT, S_RT_STEP, S_RT_RND, S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pass_r, pass_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_IDLE;
    cmd.k         = cnt_r;
    cmd.pass      = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        pass_nxt  = 1'b0;
        state_nxt = stat.special ? S_FINISH : S_SQ_INIT;
      end
      S_SQ_INIT: begin
        cmd.op    = OP_SQ_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        cmd.op  = OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) state_nxt = S_BS;
      end
      S_BS: begin
        cmd.op    = OP_BS_MUL;
        state_nxt = S_DV_INIT;
      end
      S_DV_INIT: begin
        cmd.op    = OP_DV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DV_STEP;
      end
      S_DV_STEP: begin
        cmd.op  = OP_DV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DV_STEPS - 1)) state_nxt = S_HSQ;
      end
      S_HSQ: begin
        cmd.op    = OP_HSQ_MUL;
        state_nxt = S_SER_INIT;
      end
      S_SER_INIT: begin
        cmd.op    = OP_SER_INIT;
        cnt_nxt   = CNT_W'(1);
        state_nxt = S_T_REC;
      end
      S_T_REC: begin cmd.op = OP_T_REC; state_nxt = S_T_CHK; end
      S_T_CHK: begin cmd.op = OP_T_CHK; state_nxt = S_T_FIX; end
      S_T_FIX: begin cmd.op = OP_T_FIX; state_nxt = S_T_HI;  end
      S_T_HI:  begin cmd.op = OP_T_HI;  state_nxt = S_T_LO;  end
      S_T_LO:  begin cmd.op = OP_T_LO;  state_nxt = S_T_L16; end
      S_T_L16: begin cmd.op = OP_T_L16; state_nxt = S_T_SUM; end
      S_T_SUM: begin cmd.op = OP_T_SUM; state_nxt = S_T_ACC; end
      S_T_ACC: begin
        cmd.op = OP_T_ACC;
        if (stat.term_zero || cnt_r == CNT_W'(SERIES_TERMS)) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = S_HSQ;
          end else begin
            state_nxt = S_RT_INIT;
          end
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_T_REC;
        end
      end
      S_RT_INIT: begin
        cmd.op    = OP_RT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_RT_STEP;
      end
      S_RT_STEP: begin
        cmd.op  = OP_RT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RT_STEPS - 1)) state_nxt = S_RT_RND;
      end
      S_RT_RND: begin
        cmd.op    = OP_RT_RND;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/kwc_dpath.sv
// Kaiser window coefficient unit: datapath.
// Bit-pair square root, restoring divider, shared 33x24 multiplier for the series,
// ratio divider and output register. Depends on kwc_pkg.
module kwc_dpath import kwc_pkg::*; (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [IDX_W-1:0]   in_sample_index,
  input  logic [LEN_W-1:0]   window_length,
  input  logic [BETA_W-1:0]  beta_q11,
  output stat_t              stat,
  output logic [COEF_W-1:0]  out_coefficient,
  output logic               out_index_out_of_range
);

  // load stage
  logic [LEN_W-1:0] len_sat, d13, two_i, m13, dm, dp;
  logic [11:0]      d_r;
  logic [23:0]      rad_r;
  logic             oor_r, one_r;

  // sqrt
  logic [53:0] sq_op_r;
  logic [27:0] sq_rem_r;
  logic [26:0] sq_root_r;
  logic [29:0] sq_t;
  logic [28:0] sq_trial;
  logic        sq_ge;

  // divide
  logic [31:0] dv_n_r;
  logic [11:0] dv_rem_r;
  logic [19:0] dv_q_r;
  logic [12:0] dv_t;
  logic        dv_ge;

  // series
  logic [32:0] mul_a;
  logic [23:0] mul_b;
  logic [56:0] prod_r;
  logic [23:0] x_r, r2_r, q0;
  logic [11:0] k2_r;
  logic [63:0] term_r, sum_r, num_r, acc_r;
  logic [19:0] h_sel;

  // ratio
  logic [64:0] rt_rem_r, rt_sh;
  logic [15:0] rt_q_r;
  logic        rt_ge_r;
  logic [15:0] coef_r;
  logic        flag_r;

  assign len_sat = (window_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : window_length;
  assign d13     = len_sat - LEN_W'(1);
  assign two_i   = {in_sample_index, 1'b0};
  assign m13     = (two_i >= d13) ? (two_i - d13) : (d13 - two_i);
  assign dm      = d13 - m13;
  assign dp      = d13 + m13;

  assign sq_t     = {sq_rem_r, sq_op_r[53:52]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = (sq_t >= {1'b0, sq_trial});

  assign dv_t  = {dv_rem_r, dv_n_r[31]};
  assign dv_ge = (dv_t >= {1'b0, d_r});

  assign h_sel = cmd.pass ? {beta_q11, 4'b0000} : dv_q_r;
  assign q0    = prod_r[55:32];
  assign rt_sh = {rt_rem_r[63:0], 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_BS_MUL:  begin mul_a = 33'(sq_root_r); mul_b = 24'(beta_q11); end
      OP_HSQ_MUL: begin mul_a = 33'(h_sel);     mul_b = 24'(h_sel);    end
      OP_T_REC:   begin mul_a = RECIP_TBL[cmd.k]; mul_b = x_r;         end
      OP_T_CHK:   begin mul_a = 33'(q0);        mul_b = 24'(k2_r);     end
      OP_T_HI:    begin mul_a = 33'(term_r[63:40]); mul_b = r2_r;      end
      OP_T_LO:    begin mul_a = 33'(term_r[39:16]); mul_b = r2_r;      end
      OP_T_L16:   begin mul_a = 33'(term_r[15:0]);  mul_b = r2_r;      end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        d_r   <= d13[11:0];
        rad_r <= 24'(dm) * 24'(dp);
        oor_r <= ({1'b0, in_sample_index} >= len_sat);
        one_r <= (len_sat == LEN_W'(1));
      end
      OP_SQ_INIT: begin
        sq_op_r   <= {rad_r, 30'b0};
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      OP_SQ_STEP: begin
        sq_op_r <= {sq_op_r[51:0], 2'b00};
        if (sq_ge) begin
          sq_rem_r  <= 28'(sq_t - {1'b0, sq_trial});
          sq_root_r <= {sq_root_r[25:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_t[27:0];
          sq_root_r <= {sq_root_r[25:0], 1'b0};
        end
      end
      OP_DV_INIT: begin
        dv_n_r   <= prod_r[42:11];
        dv_rem_r <= '0;
        dv_q_r   <= '0;
      end
      OP_DV_STEP: begin
        dv_n_r   <= {dv_n_r[30:0], 1'b0};
        dv_rem_r <= dv_ge ? 12'(dv_t - {1'b0, d_r}) : dv_t[11:0];
        dv_q_r   <= {dv_q_r[18:0], dv_ge};
      end
      OP_HSQ_MUL: begin
        if (cmd.pass) num_r <= sum_r;
      end
      OP_SER_INIT: begin
        x_r    <= prod_r[39:16];
        sum_r  <= ONE_Q16;
        term_r <= ONE_Q16;
        k2_r   <= 12'd1;
      end
      OP_T_CHK: r2_r <= q0;
      OP_T_FIX: begin
        // reciprocal estimate is at most one low
        if ((x_r - prod_r[23:0]) >= 24'(k2_r)) r2_r <= r2_r + 24'd1;
      end
      OP_T_LO:  acc_r <= {prod_r[39:0], 24'b0};
      OP_T_L16: acc_r <= acc_r + 64'(prod_r);
      OP_T_SUM: term_r <= acc_r + 64'(prod_r[56:16]);
      OP_T_ACC: begin
        if (term_r != '0) sum_r <= sum_r + term_r;
        k2_r <= k2_r + 12'({cmd.k, 1'b1});
      end
      OP_RT_INIT: begin
        rt_rem_r <= {1'b0, num_r};
        rt_q_r   <= '0;
        rt_ge_r  <= (num_r >= sum_r);
      end
      OP_RT_STEP: begin
        if (rt_sh >= {1'b0, sum_r}) begin
          rt_rem_r <= rt_sh - {1'b0, sum_r};
          rt_q_r   <= {rt_q_r[14:0], 1'b1};
        end else begin
          rt_rem_r <= rt_sh;
          rt_q_r   <= {rt_q_r[14:0], 1'b0};
        end
      end
      OP_RT_RND: begin
        if (rt_ge_r)                        rt_q_r <= ONE_Q15;
        else if (rt_sh >= {1'b0, sum_r})    rt_q_r <= rt_q_r + 16'd1;
      end
      OP_OUT: begin
        flag_r <= oor_r;
        if (oor_r)      coef_r <= '0;
        else if (one_r) coef_r <= ONE_Q15;
        else            coef_r <= rt_q_r;
      end
      default: ;
    endcase
  end

  assign stat.special          = oor_r || one_r;
  assign stat.term_zero        = (term_r == '0);
  assign out_coefficient       = coef_r;
  assign out_index_out_of_range = flag_r;

endmodule

### tb/sv/kwc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the Kaiser window coefficient unit: it tracks register writes,
// predicts each coefficient, and compares it with the out_ channel.
// Depends on kwc_pkg.
module kwc_result_checker import kwc_pkg::*; #(
  parameter logic [2:0] LEN_ADDR  = 3'd0,
  parameter logic [2:0] BETA_ADDR = 3'd4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [IDX_W-1:0]  in_sample_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [COEF_W-1:0] out_coefficient,
  input  logic              out_index_out_of_range,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_words,
  output int                checked_words
);

  typedef struct {
    logic [COEF_W-1:0] coef;
    logic              oor;
  } coef_word_t;

  coef_word_t        coef_fifo[$];
  logic [LEN_W-1:0]  len_shadow;
  logic [BETA_W-1:0] beta_shadow;

  function automatic logic [63:0] root_of(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // I0(2h) in Q16, h in Q16
  function automatic logic [63:0] bessel_sum(input logic [63:0] h);
    logic [63:0] hsq, sum, term, r2, k;
    hsq  = h * h;
    sum  = ONE_Q16;
    term = ONE_Q16;
    for (k = 1; k <= SERIES_TERMS; k++) begin
      r2   = hsq / ((k * k) << 16);
      term = (term >> 16) * r2 + (((term & 64'hFFFF) * r2) >> 16);
      if (term == 0) break;
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [15:0] q15_quotient(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [31:0] q;
    if (num >= den) return ONE_Q15;
    rem = num;
    q   = 0;
    for (int i = 0; i < 15; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    if ((rem << 1) >= den) q = q + 1;
    return (q > ONE_Q15) ? ONE_Q15 : q[15:0];
  endfunction

  function automatic coef_word_t predict_coef(input logic [IDX_W-1:0] idx);
    coef_word_t  w;
    logic [63:0] len, d, m, s, h;
    len = len_shadow;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    w.oor  = 1'b0;
    w.coef = '0;
    if (idx >= len) begin
      w.oor = 1'b1;
    end else if (len == 1) begin
      w.coef = ONE_Q15;
    end else begin
      d = len - 1;
      m = (2 * idx >= d) ? (2 * idx - d) : (d - 2 * idx);
      s = root_of((d * d - m * m) << 30);
      h = (64'(beta_shadow) * s) / (d << 11);
      w.coef = q15_quotient(bessel_sum(h), bessel_sum(64'(beta_shadow) << 4));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    checked_words = 0;
  end

  assign pending_words = coef_fifo.size();

  always @(posedge clk) begin
    coef_word_t w;
    if (!rst_n) begin
      len_shadow  <= 13'd64;
      beta_shadow <= 16'd16384;
      coef_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == LEN_ADDR) len_shadow <= pwdata[LEN_W-1:0];
        else if (paddr == BETA_ADDR) beta_shadow <= pwdata[BETA_W-1:0];
      end
      if (in_valid && in_ready) coef_fifo.push_back(predict_coef(in_sample_index));
      if (out_valid && out_ready) begin
        if (coef_fifo.size() == 0) begin
          $display("%0t: unexpected output word, coefficient %0d", $realtime, out_coefficient);
          fail_count++;
        end else begin
          w = coef_fifo.pop_front();
          checked_words++;
          if (out_coefficient !== w.coef)
            report_mismatch("coefficient", out_coefficient, w.coef);
          if (out_index_out_of_range !== w.oor)
            report_mismatch("index_out_of_range", out_index_out_of_range, w.oor);
        end
      end
    end
  end

endmodule

### tb/sv/tb_kaiser_window_coefficient_unit.sv
`timescale 1ns / 100ps
// Testbench top for the Kaiser window coefficient unit: clock, reset, APB writes,
// index stimulus with random gaps and stalls, and the verdict.
// Depends on kwc_pkg, kaiser_window_coefficient_unit and kwc_result_checker.
module tb_kaiser_window_coefficient_unit;
  import kwc_pkg::*;

  localparam logic [2:0] LEN_ADDR  = 3'd0;
  localparam logic [2:0] BETA_ADDR = 3'd4;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [IDX_W-1:0]  in_sample_index;
  logic              out_valid;
  logic              out_ready;
  logic [COEF_W-1:0] out_coefficient;
  logic              out_index_out_of_range;
  logic              psel, penable, pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count, pending_words, checked_words;
  int                sent_words;
  int                cur_len;
  bit                hold_req;

  kaiser_window_coefficient_unit i_dut (.*);

  kwc_result_checker #(.LEN_ADDR(LEN_ADDR), .BETA_ADDR(BETA_ADDR)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_word(input logic [IDX_W-1:0] idx, input int gap);
    in_valid        <= 1'b1;
    in_sample_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_window(input int len, input int beta);
    drain();
    reg_write(LEN_ADDR, len);
    reg_write(BETA_ADDR, beta);
    cur_len = (len > MAX_LENGTH) ? MAX_LENGTH : len;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (cur_len > 0 && $urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, cur_len - 1));
    return IDX_W'($urandom_range(0, 4095));
  endfunction

  initial begin
    int len, beta, r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    sent_words = 0;
    cur_len = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, edges of the index range, tiny and saturated lengths
    send_word(0, 0);  send_word(31, 1); send_word(32, 0);
    send_word(63, 0); send_word(64, 2); send_word(4095, 0);
    set_window(1, 16384);     send_word(0, 0); send_word(1, 0);
    set_window(0, 16384);     send_word(0, 0); send_word(4095, 0);
    set_window(8191, 65535);  send_word(0, 0); send_word(2048, 1); send_word(4095, 0);
    set_window(4096, 0);      send_word(0, 0); send_word(2047, 0); send_word(4095, 0);
    set_window(2, 65535);     send_word(0, 0); send_word(1, 0); send_word(2, 0);
    set_window(3, 65535);     send_word(1, 0); send_word(0, 0);

    for (int ph = 0; ph < 10; ph++) begin
      r = $urandom_range(0, 9);
      if (r < 4) len = $urandom_range(2, 64);
      else if (r < 7) len = $urandom_range(2, 4096);
      else if (r == 7) len = $urandom_range(0, 1);
      else len = $urandom_range(4096, 8191);
      r = $urandom_range(0, 5);
      beta = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
      set_window(len, beta);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 83; n++) begin
        if (ph == 5 && n == 40) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_words != 0) @(posedge clk);
        end
        send_word(pick_index(), (ph == 2) ? 0 : pick_gap());
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d indices over 16 window settings, checked %0d coefficients.",
             sent_words, checked_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
